// ===== sv/jlc_pkg.sv =====
package jlc_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int TAG_W  = 16;
  localparam int ACT_W  = 2;
  localparam int STAT_W = 3;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_LIST   = 2'd2;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_CANCELED = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd3;
  localparam logic [STAT_W-1:0] ST_ENTRY    = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

  // Source of the result tag
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_IN,
    SRC_NEWEST,
    SRC_LIST
  } tag_src_t;

  // Controller to datapath
  typedef struct packed {
    logic              add_wr;
    logic              stk_rd;
    logic              scan_init;
    logic              scan_run;
    logic              shift_en;
    logic              cnt_dec;
    logic              emit;
    logic [STAT_W-1:0] emit_status;
    tag_src_t          emit_src;
    logic              emit_last;
  } jlc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic data_valid;
    logic scan_done;
  } jlc_stat_t;

endpackage

// ===== sv/jlc_ctrl.sv =====
module jlc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [jlc_pkg::ACT_W-1:0]   in_action,
  input  jlc_pkg::jlc_stat_t          stat,
  output jlc_pkg::jlc_cmd_t           cmd,
  output logic                        busy
);
  import jlc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CANCEL,
    S_LIST
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (in_action)
            ACT_ADD: begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (stat.full) begin
                cmd.emit_status = ST_FULL;
                cmd.emit_src    = SRC_ZERO;
              end else begin
                cmd.add_wr      = 1'b1;
                cmd.emit_status = ST_ADDED;
                cmd.emit_src    = SRC_IN;
              end
            end
            ACT_CANCEL: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = ST_NONE;
                cmd.emit_src    = SRC_ZERO;
              end else begin
                cmd.stk_rd    = 1'b1;
                cmd.scan_init = 1'b1;
                state_nxt     = S_CANCEL;
              end
            end
            ACT_LIST: begin
              if (stat.empty) begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = ST_EMPTY;
                cmd.emit_src    = SRC_ZERO;
              end else begin
                cmd.scan_init = 1'b1;
                state_nxt     = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end
      S_CANCEL: begin
        cmd.scan_run = 1'b1;
        cmd.shift_en = 1'b1;
        if (stat.scan_done) begin
          cmd.cnt_dec     = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = ST_CANCELED;
          cmd.emit_src    = SRC_NEWEST;
          state_nxt       = S_IDLE;
        end
      end
      S_LIST: begin
        cmd.scan_run = 1'b1;
        if (stat.data_valid) begin
          cmd.emit        = 1'b1;
          cmd.emit_last   = stat.scan_done;
          cmd.emit_status = ST_ENTRY;
          cmd.emit_src    = SRC_LIST;
        end
        if (stat.scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// ===== sv/jlc_dp.sv =====
module jlc_dp #(
  parameter int DEPTH = jlc_pkg::DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  jlc_pkg::jlc_cmd_t            cmd,
  input  logic [jlc_pkg::TAG_W-1:0]    in_job_tag,
  output jlc_pkg::jlc_stat_t           stat,
  output logic                         out_valid,
  output logic [jlc_pkg::STAT_W-1:0]   out_status,
  output logic [jlc_pkg::TAG_W-1:0]    out_tag_out,
  output logic                         out_last
);
  import jlc_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [TAG_W-1:0] job_store   [DEPTH];
  logic [TAG_W-1:0] order_stack [DEPTH];

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic              pipe_v_r;
  logic              found_r;
  logic [TAG_W-1:0]  job_q_r;
  logic [TAG_W-1:0]  stk_q_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  top_idx;
  logic [CNT_W-1:0]  didx;
  logic [CNT_W-1:0]  shift_pos;
  logic              rd_en;
  logic              match;
  logic              shift_wr;
  logic [TAG_W-1:0]  tag_sel;

  assign top_idx   = count_r - ONE_C;
  assign didx      = idx_r - ONE_C;   // index of the entry in job_q_r
  assign shift_pos = didx - ONE_C;
  assign rd_en     = cmd.scan_run && (idx_r < count_r);
  assign match     = (job_q_r == stk_q_r);
  assign shift_wr  = cmd.shift_en && pipe_v_r && found_r;

  // Stores: one write and one registered read each per cycle
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      job_store[count_r[IDX_W-1:0]]   <= in_job_tag;
      order_stack[count_r[IDX_W-1:0]] <= in_job_tag;
    end else if (shift_wr) begin
      job_store[shift_pos[IDX_W-1:0]] <= job_q_r;
    end
    if (rd_en) begin
      job_q_r <= job_store[idx_r[IDX_W-1:0]];
    end
    if (cmd.stk_rd) begin
      stk_q_r <= order_stack[top_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      pipe_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.add_wr) begin
        count_r <= count_r + ONE_C;
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - ONE_C;
      end
      if (cmd.scan_init) begin
        idx_r    <= '0;
        pipe_v_r <= 1'b0;
        found_r  <= 1'b0;
      end else begin
        pipe_v_r <= rd_en;
        if (rd_en) begin
          idx_r <= idx_r + ONE_C;
        end
        if (cmd.shift_en && pipe_v_r && match) begin
          found_r <= 1'b1;
        end
      end
      out_valid_r <= cmd.emit;
    end
  end

  always_comb begin
    case (cmd.emit_src)
      SRC_IN:     tag_sel = in_job_tag;
      SRC_NEWEST: tag_sel = stk_q_r;
      SRC_LIST:   tag_sel = job_q_r;
      default:    tag_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_tag_r    <= tag_sel;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r >= DEPTH_C);
  assign stat.data_valid = pipe_v_r;
  assign stat.scan_done  = pipe_v_r && (didx == top_idx);

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_tag_out = out_tag_r;
  assign out_last    = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_wr |-> (count_r < DEPTH_C))
    else $error("add written into full store");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (count_r != '0))
    else $error("cancel on empty store");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    shift_wr |-> ((didx != '0) && (didx < count_r)))
    else $error("shift write outside held entries");

endmodule

// ===== sv/job_list_with_cancel_last.sv =====
// Job list with cancel-last. Send a request by raising start with in_action
// and in_job_tag while busy is low; the request is taken at that clock edge.
// Results appear on out_status/out_tag_out/out_last for exactly one cycle,
// marked by out_valid, and the receiver cannot stall them: sample every cycle
// that out_valid is high. out_last marks the final result of a request. An
// add, a full add, a cancel on an empty list and a list on an empty list give
// their single result the cycle after the request and leave busy low, so the
// next request may follow at once. A cancel or a non-empty list walks the N
// held entries through the single read port of the job store, one entry a
// cycle through a registered read: busy stays high until the walk is done,
// and the next request is taken once busy is low again. List entries stream
// out one per cycle, oldest first. Action code 3 is dropped with no result.
// The stores need no clearing after reset.
module job_list_with_cancel_last #(
  parameter int DEPTH = jlc_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [jlc_pkg::ACT_W-1:0]   in_action,
  input  logic [jlc_pkg::TAG_W-1:0]   in_job_tag,
  output logic                        out_valid,
  output logic [jlc_pkg::STAT_W-1:0]  out_status,
  output logic [jlc_pkg::TAG_W-1:0]   out_tag_out,
  output logic                        out_last
);
  import jlc_pkg::*;

  jlc_cmd_t  cmd;
  jlc_stat_t stat;

  // Sequence each request: decode, walk the store, emit results
  jlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Hold the job store, order stack, entry count and result register
  jlc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_job_tag  (in_job_tag),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_tag_out (out_tag_out),
    .out_last    (out_last)
  );

  // An accepted cancel either answers at once or occupies the block
  a_cancel_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_CANCEL)) |=> (busy || out_valid))
    else $error("cancel request dropped");

endmodule

// ===== bench/job_list_with_cancel_last_test.sv =====
module job_list_with_cancel_last_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jlc_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  // Action code the block must drop without any result.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  // Cycle limit for the slowest legal run, with a wide margin.
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } job_result_t;

  // Tracks the job list and the add order, and holds the results the block
  // still owes, oldest first.
  class job_ledger;
    logic [TAG_W-1:0] list_tags[$];
    logic [TAG_W-1:0] add_order[$];
    job_result_t      pending_results[$];
    int               failures = 0;

    function void queue_result(logic [STAT_W-1:0] status, logic [TAG_W-1:0] tag,
                               logic last);
      job_result_t r;
      r.status = status;
      r.tag    = tag;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction

    // Predict the results of one accepted request and update the lists.
    function void note_request(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag);
      logic [TAG_W-1:0] newest;
      int pos;
      case (act)
        ACT_ADD: begin
          if (list_tags.size() >= DEPTH) begin
            queue_result(ST_FULL, '0, 1'b1);
          end else begin
            list_tags.push_back(tag);
            add_order.push_back(tag);
            queue_result(ST_ADDED, tag, 1'b1);
          end
        end
        ACT_CANCEL: begin
          if (list_tags.size() == 0) begin
            queue_result(ST_NONE, '0, 1'b1);
          end else begin
            newest = add_order.pop_back();
            // Remove the first match; fall back to the newest list entry.
            pos = list_tags.size() - 1;
            for (int i = 0; i < list_tags.size(); i++) begin
              if (list_tags[i] == newest) begin
                pos = i;
                break;
              end
            end
            list_tags.delete(pos);
            queue_result(ST_CANCELED, newest, 1'b1);
          end
        end
        ACT_LIST: begin
          if (list_tags.size() == 0) begin
            queue_result(ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (list_tags[i])
              queue_result(ST_ENTRY, list_tags[i], i == list_tags.size() - 1);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one result from the block with the oldest pending one.
    function void check_result(logic [STAT_W-1:0] status, logic [TAG_W-1:0] tag,
                               logic last);
      job_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status=%0d tag_out=%h last=%0d", status, tag, last);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        $error("out_status: expected %0d, actual %0d", want.status, status);
        failures++;
      end
      if (tag !== want.tag) begin
        $error("out_tag_out: expected %h, actual %h", want.tag, tag);
        failures++;
      end
      if (last !== want.last) begin
        $error("out_last: expected %0d, actual %0d", want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [ACT_W-1:0]  in_action;
  logic [TAG_W-1:0]  in_job_tag;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [TAG_W-1:0]  out_tag_out;
  logic              out_last;

  job_ledger ledger = new();
  int        cycle_count = 0;
  // When set, requests go back to back with no idle cycles.
  bit        no_idle = 1'b0;

  job_list_with_cancel_last #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_job_tag (in_job_tag),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_tag_out(out_tag_out),
    .out_last   (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard the run against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Results cannot be held off: sample every strobed cycle at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      ledger.check_result(out_status, out_tag_out, out_last);
  end

  // Drive one request. Start is left high after acceptance so a back-to-back
  // request never lowers and raises it in the same time step; the next call
  // drops it only when it idles first.
  task automatic send_request(logic [ACT_W-1:0] act, logic [TAG_W-1:0] tag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      <= 1'b1;
    in_action  <= act;
    in_job_tag <= tag;
    // Hold the request until an edge sees busy low.
    do @(posedge clk); while (busy);
    ledger.note_request(act, tag);
  endtask

  // Pause the sender until every owed result has come out.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending_count() != 0) @(posedge clk);
  endtask

  // Mostly fresh random tags, a quarter from a tiny pool so duplicates appear
  // and cancel has to pick the first match.
  function automatic logic [TAG_W-1:0] pick_tag();
    if ($urandom_range(0, 3) == 0)
      return TAG_W'($urandom_range(0, 7));
    return TAG_W'($urandom_range(0, 65535));
  endfunction

  // Random requests with the given percentages for add, cancel and list;
  // the rest are unused codes.
  task automatic run_phase(int items, int add_pct, int cancel_pct, int list_pct,
                           bit keep_busy);
    int r;
    logic [ACT_W-1:0] act;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < add_pct)
        act = ACT_ADD;
      else if (r < add_pct + cancel_pct)
        act = ACT_CANCEL;
      else if (r < add_pct + cancel_pct + list_pct)
        act = ACT_LIST;
      else
        act = ACT_UNUSED;
      // Flip between idling and back-to-back stretches now and then, unless keep_busy holds back to back.
      if (keep_busy)
        no_idle = 1'b1;
      else if ($urandom_range(0, 9) == 0)
        no_idle = ~no_idle;
      send_request(act, pick_tag());
    end
  endtask

  initial begin
    start      = 1'b0;
    in_action  = ACT_ADD;
    in_job_tag = '0;
    rst_n      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty cases first, back to back.
    no_idle = 1'b1;
    send_request(ACT_LIST, 16'h0000);
    send_request(ACT_CANCEL, 16'hFFFF);
    send_request(ACT_UNUSED, 16'h1234);
    send_request(ACT_ADD, 16'h0000);
    send_request(ACT_ADD, 16'hFFFF);
    send_request(ACT_ADD, 16'h1234);
    send_request(ACT_ADD, 16'h0000);
    send_request(ACT_LIST, 16'h0000);
    // Cancel of a duplicate tag drops the oldest copy.
    send_request(ACT_CANCEL, 16'h0000);
    send_request(ACT_LIST, 16'hFFFF);
    no_idle = 1'b0;
    send_request(ACT_UNUSED, 16'hFFFF);
    send_request(ACT_CANCEL, 16'h0000);
    send_request(ACT_CANCEL, 16'h0000);
    send_request(ACT_CANCEL, 16'h0000);
    send_request(ACT_CANCEL, 16'h0000);
    send_request(ACT_LIST, 16'h0000);
    send_request(ACT_ADD, 16'hA5A5);
    send_request(ACT_ADD, 16'h5A5A);
    send_request(ACT_ADD, 16'hA5A5);
    send_request(ACT_CANCEL, 16'h0000);
    send_request(ACT_LIST, 16'h0000);
    drain_results();

    // Random: mixed traffic, then fill past full, then back to back, then
    // drain past empty. Pause for all results between phases.
    run_phase(40, 45, 25, 25, 1'b0);
    drain_results();
    run_phase(50, 90, 3, 5, 1'b0);
    drain_results();
    run_phase(30, 40, 30, 28, 1'b1);
    no_idle = 1'b0;
    drain_results();
    run_phase(40, 8, 85, 5, 1'b0);

    drain_results();
    // Let any trailing strobe show up before the verdict.
    repeat (DEPTH + 4) @(posedge clk);
    if (ledger.failures == 0 && ledger.pending_count() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
